@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the MD5 engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MD5_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 engine assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MD5_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 engine assertion failed");

`endif

@@ sv/md5_pkg.sv @@
// Types, constants and tables shared by the MD5 engine modules.
package md5_pkg;

   localparam int WORD_W   = 32;
   localparam int CNT_W    = 3;
   localparam int IDX_W    = 2;
   localparam int BUF_DEPTH = 16;
   localparam int BUF_AW   = 4;
   localparam int ROUND_W  = 6;
   localparam int LEN_W    = 64;

   localparam logic [CNT_W-1:0] FULL_COUNT = 3'd4;
   localparam logic [7:0]       PAD_MARK   = 8'h80;
   localparam logic [BUF_AW-1:0] LEN_LO_ADDR = 4'd14;
   localparam logic [BUF_AW-1:0] LAST_ADDR   = 4'd15;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
   localparam logic [IDX_W-1:0]  LAST_INDEX = 2'd3;

   localparam logic [WORD_W-1:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROUND_SHIFT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_PREP,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      WSEL_DATA,
      WSEL_MARK,
      WSEL_ZERO,
      WSEL_LEN_LO,
      WSEL_LEN_HI
   } wsel_type;

   typedef struct packed {
      logic                buf_we;
      logic [BUF_AW-1:0]   buf_waddr;
      wsel_type            wsel;
      logic [BUF_AW-1:0]   buf_raddr;
      logic                len_add;
      logic                load_v;
      logic                round_en;
      logic [ROUND_W-1:0]  round;
      logic                chain_add;
      logic                finish;
      logic [IDX_W-1:0]    out_idx;
   } ctrl_cmd_type;

   // Bytes a request really carries: only the last word may be short.
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
                                                  input logic last);
      logic [CNT_W-1:0] res;
      res = cnt;
      if (!last || cnt > FULL_COUNT) res = FULL_COUNT;
      return res;
   endfunction

   // Message word used by a given round.
   function automatic logic [BUF_AW-1:0] msg_index(input logic [ROUND_W-1:0] r);
      logic [BUF_AW-1:0] r4;
      logic [BUF_AW-1:0] res;
      r4 = r[3:0];
      case (r[5:4])
         2'd0: res = r4;
         2'd1: res = r4 * 4'd5 + 4'd1;
         2'd2: res = r4 * 4'd3 + 4'd5;
         2'd3: res = r4 * 4'd7;
         default: res = r4;
      endcase
      return res;
   endfunction

endpackage

@@ sv/md5_if.sv @@
// Request and response channel interfaces of the MD5 engine.
interface md5_req_if import md5_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic [CNT_W-1:0]  byte_count;
   logic              is_last;

   modport source (output valid, data_word, byte_count, is_last, input ready);
   modport sink   (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface md5_rsp_if import md5_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest_word;
   logic [IDX_W-1:0]  word_index;
   logic              last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ sv/md5_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/md5_ctrl.sv @@
// Sequencer of the MD5 engine: buffer fill, padding, rounds and digest output.
module md5_ctrl import md5_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_is_last,
   input  logic [CNT_W-1:0] req_byte_count,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   state_type           state_ff, state_in;
   state_type           ret_ff, ret_in;
   logic [BUF_AW-1:0]   k_ff, k_in;
   logic                extra_ff, extra_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic [IDX_W-1:0]    out_idx_ff, out_idx_in;
   logic [CNT_W-1:0]    cnt_eff;
   logic                accept;

   assign cnt_eff = eff_count(req_byte_count, req_is_last);
   assign accept  = (state_ff == ST_IDLE) && req_valid;

   // Next state and return point after a compression.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_is_last) begin
                  state_in = ST_IDLE;
               end else if (cnt_eff < FULL_COUNT) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_MARK;
               end
               if (k_ff == LAST_ADDR) begin
                  ret_in   = state_in;
                  state_in = ST_PREP;
               end
            end
         end
         ST_MARK: begin
            if (k_ff == LAST_ADDR) begin
               ret_in   = ST_ZERO;
               state_in = ST_PREP;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (!extra_ff && k_ff == LEN_LO_ADDR) begin
               state_in = ST_LEN_LO;
            end else if (k_ff == LAST_ADDR) begin
               ret_in   = ST_ZERO;
               state_in = ST_PREP;
            end
         end
         ST_LEN_LO: state_in = ST_LEN_HI;
         ST_LEN_HI: begin
            ret_in   = ST_EMIT;
            state_in = ST_PREP;
         end
         ST_PREP:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) state_in = ST_FOLD;
         end
         ST_FOLD:  state_in = ret_ff;
         ST_EMIT: begin
            if (rsp_ready && out_idx_ff == LAST_INDEX) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath and handshake outputs.
   always_comb begin
      cmd           = '0;
      cmd.wsel      = WSEL_ZERO;
      cmd.buf_waddr = k_ff;
      cmd.round     = round_ff;
      cmd.out_idx   = out_idx_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.buf_we  = accept;
            cmd.wsel    = WSEL_DATA;
            cmd.len_add = accept;
         end
         ST_MARK: begin
            cmd.buf_we = 1'b1;
            cmd.wsel   = WSEL_MARK;
         end
         ST_ZERO: begin
            cmd.buf_we = extra_ff || (k_ff != LEN_LO_ADDR);
            cmd.wsel   = WSEL_ZERO;
         end
         ST_LEN_LO: begin
            cmd.buf_we = 1'b1;
            cmd.wsel   = WSEL_LEN_LO;
         end
         ST_LEN_HI: begin
            cmd.buf_we = 1'b1;
            cmd.wsel   = WSEL_LEN_HI;
         end
         ST_PREP: begin
            cmd.load_v    = 1'b1;
            cmd.buf_raddr = msg_index('0);
         end
         ST_ROUND: begin
            cmd.round_en  = 1'b1;
            cmd.buf_raddr = msg_index(round_ff + 6'd1);
         end
         ST_FOLD:  cmd.chain_add = 1'b1;
         ST_EMIT: begin
            rsp_valid  = 1'b1;
            cmd.finish = rsp_ready && (out_idx_ff == LAST_INDEX);
         end
         default: ;
      endcase
   end

   // Word pointer, extra-block flag, round and output counters.
   always_comb begin
      k_in       = k_ff;
      extra_in   = extra_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in = k_ff + 4'd1;
               if (req_is_last && cnt_eff < FULL_COUNT) extra_in = (k_ff == LEN_LO_ADDR);
            end
         end
         ST_MARK: begin
            k_in     = k_ff + 4'd1;
            extra_in = (k_ff == LEN_LO_ADDR);
         end
         ST_ZERO: begin
            if (extra_ff || k_ff != LEN_LO_ADDR) begin
               k_in = k_ff + 4'd1;
               if (k_ff == LAST_ADDR) extra_in = 1'b0;
            end
         end
         ST_LEN_LO: k_in = k_ff + 4'd1;
         ST_LEN_HI: k_in = k_ff + 4'd1;
         ST_PREP:   round_in = '0;
         ST_ROUND:  round_in = round_ff + 6'd1;
         ST_EMIT: begin
            if (rsp_ready) out_idx_in = out_idx_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         k_ff       <= '0;
         extra_ff   <= 1'b0;
         round_ff   <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         k_ff       <= k_in;
         extra_ff   <= extra_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
      end
   end

endmodule

@@ sv/md5_datapath.sv @@
// MD5 datapath: block buffer, length counter, round unit and chaining words.
module md5_datapath import md5_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  logic [WORD_W-1:0] req_data_word,
   input  logic [CNT_W-1:0]  req_byte_count,
   input  logic              req_is_last,
   output logic [WORD_W-1:0] digest_word,
   output logic [IDX_W-1:0]  word_index,
   output logic              last_word
);

   logic [WORD_W-1:0] chain_ff [4];
   logic [WORD_W-1:0] chain_in [4];
   logic [WORD_W-1:0] va_ff, vb_ff, vc_ff, vd_ff;
   logic [WORD_W-1:0] va_in, vb_in, vc_in, vd_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  bit_len;
   logic [CNT_W-1:0]  cnt_eff;
   logic [WORD_W-1:0] data_masked;
   logic [WORD_W-1:0] buf_wdata;
   logic [WORD_W-1:0] buf_rdata;
   logic [WORD_W-1:0] fval, sum, rot;
   logic [2*WORD_W-1:0] dbl;
   logic [WORD_W-1:0] sel_chain;

   assign cnt_eff = eff_count(req_byte_count, req_is_last);
   assign bit_len = {len_ff[LEN_W-4:0], 3'b000};

   // Keep message bytes, put the pad marker right after them in a short word, zero the rest.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (CNT_W'(i) < cnt_eff) begin
            data_masked[8*i +: 8] = req_data_word[8*i +: 8];
         end else if (CNT_W'(i) == cnt_eff) begin
            data_masked[8*i +: 8] = PAD_MARK;
         end else begin
            data_masked[8*i +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      case (cmd.wsel)
         WSEL_DATA:   buf_wdata = data_masked;
         WSEL_MARK:   buf_wdata = {24'h000000, PAD_MARK};
         WSEL_ZERO:   buf_wdata = '0;
         WSEL_LEN_LO: buf_wdata = bit_len[WORD_W-1:0];
         WSEL_LEN_HI: buf_wdata = bit_len[LEN_W-1:WORD_W];
         default:     buf_wdata = '0;
      endcase
   end

   md5_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BUF_DEPTH)
   ) u_buf (
      .clock (clock),
      .we    (cmd.buf_we),
      .waddr (cmd.buf_waddr),
      .wdata (buf_wdata),
      .raddr (cmd.buf_raddr),
      .rdata (buf_rdata)
   );

   // One MD5 round per cycle.
   always_comb begin
      case (cmd.round[5:4])
         2'd0:    fval = (vb_ff & vc_ff) | (~vb_ff & vd_ff);
         2'd1:    fval = (vd_ff & vb_ff) | (~vd_ff & vc_ff);
         2'd2:    fval = vb_ff ^ vc_ff ^ vd_ff;
         2'd3:    fval = vc_ff ^ (vb_ff | ~vd_ff);
         default: fval = '0;
      endcase
      sum = fval + va_ff + ROUND_K[cmd.round] + buf_rdata;
      dbl = {sum, sum} << ROUND_SHIFT[{cmd.round[5:4], cmd.round[1:0]}];
      rot = dbl[2*WORD_W-1:WORD_W];
   end

   always_comb begin
      va_in = va_ff;
      vb_in = vb_ff;
      vc_in = vc_ff;
      vd_in = vd_ff;
      if (cmd.load_v) begin
         va_in = chain_ff[0];
         vb_in = chain_ff[1];
         vc_in = chain_ff[2];
         vd_in = chain_ff[3];
      end else if (cmd.round_en) begin
         va_in = vd_ff;
         vd_in = vc_ff;
         vc_in = vb_ff;
         vb_in = vb_ff + rot;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.finish) begin
         chain_in = CHAIN_INIT;
      end else if (cmd.chain_add) begin
         chain_in[0] = chain_ff[0] + va_ff;
         chain_in[1] = chain_ff[1] + vb_ff;
         chain_in[2] = chain_ff[2] + vc_ff;
         chain_in[3] = chain_ff[3] + vd_ff;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.finish) begin
         len_in = '0;
      end else if (cmd.len_add) begin
         len_in = len_ff + LEN_W'(cnt_eff);
      end
   end

   always_ff @(posedge clock) begin
      va_ff <= va_in;
      vb_ff <= vb_in;
      vc_ff <= vc_in;
      vd_ff <= vd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_INIT;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
      end
   end

   assign sel_chain   = chain_ff[cmd.out_idx];
   assign digest_word = {sel_chain[7:0], sel_chain[15:8], sel_chain[23:16], sel_chain[31:24]};
   assign word_index  = cmd.out_idx;
   assign last_word   = (cmd.out_idx == LAST_INDEX);

endmodule

@@ sv/md5_hash_engine.sv @@
// Top level of the streaming MD5 digest engine.
//
// Requests carry 1 to 4 message bytes (first byte in bits 7..0) with a byte
// count and a last flag; only the last word of a message may be short, and a
// last word with a count of 0 ends the message without adding bytes (an empty
// message is allowed). A request is taken whenever the engine is idle. Every
// 16th word starts a compression: a load of the working words, 64 rounds at
// one round per cycle in the round unit, and one fold into the chaining
// words; no request is taken meanwhile. After the last word the engine
// writes the pad marker, zero words and the 64-bit bit length into the block
// buffer, one word per cycle outside a compression, with a spare step that
// writes nothing ahead of the length, runs one compression, or two when the
// final block holds 56 or more bytes, and then presents the four digest
// words A, B, C, D on the response channel, byte-swapped so the hex reads as
// the usual MD5 string, word_index 0 to 3 with last_word on D. Each digest
// word waits for rsp.ready; no request is taken until D is delivered, after
// which the engine starts a fresh message. The block buffer is a 16 x 32 RAM
// that needs no clearing after reset.
module md5_hash_engine import md5_pkg::*; (
   input logic     clock,
   input logic     reset,
   md5_req_if.sink req,
   md5_rsp_if.source rsp
);

   ctrl_cmd_type cmd;

   // Sequence fill, padding, rounds and output.
   md5_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_is_last    (req.is_last),
      .req_byte_count (req.byte_count),
      .req_ready      (req.ready),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .cmd            (cmd)
   );

   // Hold the buffer, the length and the chaining words; run the rounds.
   md5_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data_word  (req.data_word),
      .req_byte_count (req.byte_count),
      .req_is_last    (req.is_last),
      .digest_word    (rsp.digest_word),
      .word_index     (rsp.word_index),
      .last_word      (rsp.last_word)
   );

endmodule

@@ sv/md5_checker.sv @@
// Port-level assertions for the MD5 engine and their bind to the top level.
`include "assert_macros.svh"

module md5_checker import md5_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] digest_word,
   input logic [IDX_W-1:0]  word_index,
   input logic              last_word
);

   // A stalled digest word holds.
   `MD5_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(digest_word) && $stable(word_index))

   // No request is taken while a digest is being delivered.
   `MD5_ASSERT_IMPL(a_no_req_in_rsp, clock, reset, rsp_valid, !req_ready)

   // The final flag marks word D only.
   `MD5_ASSERT_IMPL(a_last_on_d, clock, reset, rsp_valid, last_word == (word_index == LAST_INDEX))

   // Digest words follow back to back in order A to D.
   `MD5_ASSERT_NEXT(a_word_order, clock, reset, rsp_valid && rsp_ready && !last_word, rsp_valid && word_index == $past(word_index) + 2'd1)

   // A digest never shows up in the cycle right after a request.
   `MD5_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !rsp_valid)

endmodule

bind md5_hash_engine md5_checker u_md5_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .digest_word (rsp.digest_word),
   .word_index  (rsp.word_index),
   .last_word   (rsp.last_word)
);
